// File: rtl/websocket_frame_deframer_defines.svh
// assertion macros shared by the deframer rtl
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WSFD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WSFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wsfd_pkg.sv
// types and constants for the websocket frame deframer
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAIL   = 3'd5
  } wsfd_phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SHORT      = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_RSVD       = 2'd3
  } wsfd_status_t;

  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [2:0] MIN_FRAME   = 3'd6;

  typedef struct packed {
    logic         emit;
    logic [7:0]   payload_byte;
    logic         payload_valid;
    logic         frame_done;
    wsfd_status_t status;
    logic         final_fragment;
    logic [3:0]   frame_opcode;
    logic [63:0]  payload_length;
  } wsfd_result_t;

endpackage

// File: rtl/websocket_frame_deframer.sv
// websocket frame deframer top level: input handshake and result register
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_stall in_frame_byte/end    | frame bytes in
//  out     | out_valid out_stall out_payload_* etc. | results out
//
// one byte per cycle while in_stall is low; the result is registered and appears in the cycle after its transaction
// the parser state and one result register set the rate, no other loop
// rst_n is synchronous; parser state returns to the first header byte
// in_stall is high only while a held result is stalled at the output
module websocket_frame_deframer import wsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_frame_byte,
  input  logic         in_frame_end,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_payload_byte,
  output logic         out_payload_valid,
  output logic         out_frame_done,
  output logic [1:0]   out_status,
  output logic         out_final_fragment,
  output logic [3:0]   out_frame_opcode,
  output logic [63:0]  out_payload_length
);

`include "websocket_frame_deframer_defines.svh"

  logic         accept;
  wsfd_result_t step_res;
  wsfd_result_t res_r;
  logic         out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  wsfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (accept),
    .frame_byte (in_frame_byte),
    .frame_end  (in_frame_end),
    .res        (step_res)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = step_res.emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_res.emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_valid  = res_r.payload_valid;
  assign out_frame_done     = res_r.frame_done;
  assign out_status         = res_r.status;
  assign out_final_fragment = res_r.final_fragment;
  assign out_frame_opcode   = res_r.frame_opcode;
  assign out_payload_length = res_r.payload_length;

  `WSFD_ASSERT_NOW(a_result_has_cause, out_valid_r,
    res_r.payload_valid || res_r.frame_done, "result with neither payload nor frame end")
  `WSFD_ASSERT_NOW(a_status_only_at_end, out_valid_r && !res_r.frame_done,
    res_r.status == ST_OK, "status set without frame end")
  `WSFD_ASSERT_NOW(a_status_code, out_valid_r && res_r.frame_done,
    res_r.status != ST_RSVD, "reserved status code")
  `WSFD_ASSERT_NEXT(a_accept_loads, accept && step_res.emit,
    out_valid_r, "emitting transaction did not load result register")

endmodule

// File: rtl/wsfd_parser.sv
// header parser, unmasking and frame status for one byte per cycle while step_en is high
module wsfd_parser import wsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   frame_byte,
  input  logic         frame_end,
  output wsfd_result_t res
);

`include "websocket_frame_deframer_defines.svh"

  wsfd_phase_t phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic [2:0]  short_r, short_nxt;
  logic [7:0]  key_byte;
  logic        pvalid;

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state of the header walk
  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    remain_nxt = remain_r;
    kidx_nxt   = kidx_r;
    short_nxt  = (short_r < MIN_FRAME) ? short_r + 3'd1 : short_r;
    unique case (phase_r)
      PH_HDR0: begin
        fin_nxt    = frame_byte[7];
        opcode_nxt = frame_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = frame_byte[7];
        len_nxt    = '0;
        if (frame_byte[6:0] == LEN7_EXT16) begin
          phase_nxt = PH_EXT;
          hidx_nxt  = EXT16_BYTES;
        end else if (frame_byte[6:0] == LEN7_EXT64) begin
          phase_nxt = PH_EXT;
          hidx_nxt  = EXT64_BYTES;
        end else begin
          len_nxt = {57'd0, frame_byte[6:0]};
          if (frame_byte[7]) begin
            phase_nxt = PH_KEY;
            hidx_nxt  = KEY_BYTES;
          end else begin
            phase_nxt = (frame_byte[6:0] == 7'd0) ? PH_TRAIL : PH_PAYLOAD;
          end
        end
      end
      PH_EXT: begin
        len_nxt  = {len_r[55:0], frame_byte};
        hidx_nxt = hidx_r - 4'd1;
        if (hidx_nxt == 4'd0) begin
          if (masked_r) begin
            phase_nxt = PH_KEY;
            hidx_nxt  = KEY_BYTES;
          end else begin
            phase_nxt = (len_nxt == 64'd0) ? PH_TRAIL : PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        key_nxt  = {key_r[23:0], frame_byte};
        hidx_nxt = hidx_r - 4'd1;
        if (hidx_nxt == 4'd0) begin
          phase_nxt = (len_r == 64'd0) ? PH_TRAIL : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remain_nxt = remain_r - 64'd1;
        kidx_nxt   = kidx_r + 2'd1;
        if (remain_r == 64'd1) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase
    // load the byte count on the way into the payload
    if (phase_nxt == PH_PAYLOAD && phase_r != PH_PAYLOAD) begin
      remain_nxt = len_nxt;
    end
  end

  // result of this byte
  always_comb begin
    pvalid             = (phase_r == PH_PAYLOAD);
    res.emit           = pvalid || frame_end;
    res.payload_valid  = pvalid;
    res.payload_byte   = pvalid ? (frame_byte ^ key_byte) : 8'd0;
    res.frame_done     = frame_end;
    res.final_fragment = fin_nxt;
    res.frame_opcode   = opcode_nxt;
    res.payload_length = len_nxt;
    if (!frame_end) begin
      res.status = ST_OK;
    end else if (short_nxt < MIN_FRAME) begin
      res.status = ST_SHORT;
    end else if (phase_nxt != PH_TRAIL) begin
      res.status = ST_INCOMPLETE;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && frame_end)) begin
      phase_r  <= PH_HDR0;
      hidx_r   <= '0;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      remain_r <= '0;
      kidx_r   <= '0;
      short_r  <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      remain_r <= remain_nxt;
      kidx_r   <= kidx_nxt;
      short_r  <= short_nxt;
    end
  end

  `WSFD_ASSERT_NEXT(a_end_rearms, step_en && frame_end,
    phase_r == PH_HDR0 && short_r == 3'd0 && key_r == 32'd0, "frame end did not rearm parser")
  `WSFD_ASSERT_NOW(a_payload_nonzero, phase_r == PH_PAYLOAD,
    remain_r != 64'd0 && remain_r <= len_r, "payload byte count out of range")
  `WSFD_ASSERT_NOW(a_hidx_range, phase_r == PH_EXT || phase_r == PH_KEY,
    hidx_r != 4'd0 && hidx_r <= EXT64_BYTES, "header byte index out of range")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the websocket frame deframer
`timescale 1ns / 1ps

module tb_top;
  import wsfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0]   pbyte;
    logic         pvalid;
    logic         done;
    wsfd_status_t status;
    logic         fin;
    logic [3:0]   opcode;
    logic [63:0]  plen;
  } deframe_result_t;

  typedef struct {
    logic [7:0]   fbyte;
    logic         fend;
    logic         pinned;
    wsfd_status_t pin_status;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [7:0]   in_frame_byte = 8'h00;
  logic         in_frame_end = 1'b0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [7:0]   out_payload_byte;
  logic         out_payload_valid;
  logic         out_frame_done;
  logic [1:0]   out_status;
  logic         out_final_fragment;
  logic [3:0]   out_frame_opcode;
  logic [63:0]  out_payload_length;

  websocket_frame_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_frame_byte      (in_frame_byte),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_payload_valid  (out_payload_valid),
    .out_frame_done     (out_frame_done),
    .out_status         (out_status),
    .out_final_fragment (out_final_fragment),
    .out_frame_opcode   (out_frame_opcode),
    .out_payload_length (out_payload_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // directed frames: short, unmasked with trailing bytes, header cut, payload cut
  stim_row_t dir_rows [24] = '{
    '{8'h81, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b1, 1'b1, ST_SHORT},
    '{8'h81, 1'b0, 1'b0, ST_OK},
    '{8'h01, 1'b0, 1'b0, ST_OK},
    '{8'h7E, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_INCOMPLETE},
    '{8'h8A, 1'b0, 1'b0, ST_OK},
    '{8'hFE, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h03, 1'b0, 1'b0, ST_OK},
    '{8'hA5, 1'b0, 1'b0, ST_OK},
    '{8'h5A, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_INCOMPLETE}
  };

  // deframer state as predicted
  wsfd_phase_t  ph;
  logic [3:0]   hdr_left;
  logic         fin_q;
  logic [3:0]   opc_q;
  logic         mask_q;
  logic [63:0]  len_q;
  logic [31:0]  key_q;
  logic [63:0]  pay_cnt;
  logic [2:0]   seen_cnt;

  deframe_result_t pending_results [$];
  wsfd_status_t    pinned_status [$];
  deframe_result_t new_res;
  deframe_result_t exp_res;
  logic [7:0]      frame_bytes [$];
  int              errors = 0;
  int              cycles = 0;
  int              items_sent = 0;
  bit              in_calm = 1'b0;
  bit              out_calm = 1'b0;

  function automatic void clear_deframer();
    ph = PH_HDR0;
    hdr_left = '0;
    fin_q = 1'b0;
    opc_q = '0;
    mask_q = 1'b0;
    len_q = '0;
    key_q = '0;
    pay_cnt = '0;
    seen_cnt = '0;
  endfunction

  function automatic void enter_after_len();
    if (mask_q) begin
      ph = PH_KEY;
      hdr_left = KEY_BYTES;
    end else begin
      ph = (len_q == 64'd0) ? PH_TRAIL : PH_PAYLOAD;
    end
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                      output deframe_result_t r);
    logic [7:0] key_b;
    r.pbyte = 8'h00;
    r.pvalid = 1'b0;
    r.status = ST_OK;
    if (seen_cnt < MIN_FRAME) seen_cnt = seen_cnt + 3'd1;
    case (ph)
      PH_HDR0: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        mask_q = b[7];
        len_q = '0;
        if (b[6:0] == LEN7_EXT16) begin
          ph = PH_EXT;
          hdr_left = EXT16_BYTES;
        end else if (b[6:0] == LEN7_EXT64) begin
          ph = PH_EXT;
          hdr_left = EXT64_BYTES;
        end else begin
          len_q = 64'(b[6:0]);
          enter_after_len();
        end
      end
      PH_EXT: begin
        len_q = {len_q[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) enter_after_len();
      end
      PH_KEY: begin
        key_q = {key_q[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) ph = (len_q == 64'd0) ? PH_TRAIL : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // key byte 0 sits in the top byte of the key
        key_b = 8'(key_q >> (8 * (3 - int'(pay_cnt[1:0]))));
        r.pbyte = b ^ key_b;
        r.pvalid = 1'b1;
        pay_cnt = pay_cnt + 64'd1;
        if (pay_cnt >= len_q) ph = PH_TRAIL;
      end
      default: ;
    endcase
    r.done = last;
    if (last) begin
      if (seen_cnt < MIN_FRAME) r.status = ST_SHORT;
      else if (ph != PH_TRAIL) r.status = ST_INCOMPLETE;
      else r.status = ST_OK;
    end
    r.fin = fin_q;
    r.opcode = opc_q;
    r.plen = len_q;
    if (last) clear_deframer();
    return r.pvalid || last;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // predict on each input transaction, check on each output transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_frame_byte, in_frame_end, new_res)) begin
          if (new_res.done && pinned_status.size() != 0)
            new_res.status = pinned_status.pop_front();
          pending_results.push_back(new_res);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h done %0b",
                   $time, out_payload_byte, out_frame_done);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("payload_byte", 64'(exp_res.pbyte), 64'(out_payload_byte));
          check_field("payload_valid", 64'(exp_res.pvalid), 64'(out_payload_valid));
          check_field("frame_done", 64'(exp_res.done), 64'(out_frame_done));
          check_field("status", 64'(exp_res.status), 64'(out_status));
          check_field("final_fragment", 64'(exp_res.fin), 64'(out_final_fragment));
          check_field("frame_opcode", 64'(exp_res.opcode), 64'(out_frame_opcode));
          check_field("payload_length", exp_res.plen, out_payload_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // downstream stall pattern
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      n = out_calm ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_byte <= b;
    in_frame_end <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // well-formed frame with random content, sometimes cut, padded or pure noise
  task automatic build_frame();
    int kind;
    int lsel;
    int r;
    int n_pay;
    int cut;
    logic [63:0] plen;
    logic mask;
    frame_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
      return;
    end
    frame_bytes.push_back(8'($urandom));
    mask = 1'($urandom_range(0, 1));
    lsel = $urandom_range(0, 99);
    if (lsel < 70) begin
      plen = (lsel < 10) ? 64'($urandom_range(0, 125)) : 64'($urandom_range(0, 20));
      frame_bytes.push_back({mask, plen[6:0]});
    end else if (lsel < 88) begin
      r = $urandom_range(0, 9);
      if (r == 0) plen = 64'($urandom_range(126, 300));
      else if (r == 1) plen = 64'($urandom_range(0, 65535));
      else plen = 64'($urandom_range(0, 40));
      frame_bytes.push_back({mask, LEN7_EXT16});
      frame_bytes.push_back(plen[15:8]);
      frame_bytes.push_back(plen[7:0]);
    end else begin
      if ($urandom_range(0, 3) == 0) plen = {$urandom, $urandom};
      else plen = 64'($urandom_range(0, 30));
      frame_bytes.push_back({mask, LEN7_EXT64});
      for (int i = 7; i >= 0; i--) frame_bytes.push_back(plen[8*i +: 8]);
    end
    if (mask) repeat (4) frame_bytes.push_back(8'($urandom));
    // lengths too long to send end up as cut frames
    n_pay = (plen <= 64'd300) ? int'(plen) : $urandom_range(0, 6);
    repeat (n_pay) frame_bytes.push_back(8'($urandom));
    kind = $urandom_range(0, 99);
    if (kind >= 65 && kind < 82) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
    end else if (kind >= 82 && frame_bytes.size() > 1) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      repeat (cut) void'(frame_bytes.pop_back());
    end
  endtask

  initial begin
    clear_deframer();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].pinned) pinned_status.push_back(dir_rows[i].pin_status);
      send_byte(dir_rows[i].fbyte, dir_rows[i].fend);
    end
    while (items_sent < RANDOM_ITEMS) begin
      in_calm = ($urandom_range(0, 3) == 0);
      build_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/websocket_frame_deframer.sv
tb/tb_top.sv
